@@ src/clcn_pkg.sv @@
// shared types and constants for the complex linear combination norm unit
// no dependencies

package clcn_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int REG_IDX_W  = 3;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int SUM_W      = PROD_W + 3;
   localparam int NORM_W     = 64;

   localparam logic [REG_IDX_W-1:0] REG_COEF1_RE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COEF1_IM = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_COEF2_RE = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COEF2_IM = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COEF3_RE = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_COEF3_IM = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_NORM_EN  = 3'd6;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   typedef struct packed {
      data_type a_re;
      data_type a_im;
      data_type b_re;
      data_type b_im;
      data_type c_re;
      data_type c_im;
      logic     last;
   } item_type;

   typedef struct packed {
      data_type k1_re;
      data_type k1_im;
      data_type k2_re;
      data_type k2_im;
      data_type k3_re;
      data_type k3_im;
      logic     norm_en;
   } coef_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_SUM, ST_SQ, ST_ACC, ST_OUT
   } state_type;

   localparam int ITEM_W = $bits(item_type);

endpackage

@@ src/clcn_ram.sv @@
// generic single write port ram with registered read
// no dependencies

module clcn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/clcn_front.sv @@
// front: accepts beats into a small queue, hands them out to the back
// depends on clcn_pkg, clcn_ram

module clcn_front
   import clcn_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, rd_addr;
   logic [AW:0]   count_ff, count_in, unfetched;
   logic          head_valid_ff, head_valid_in;
   logic          push, pop_ram, pop_head, fetch_ok;
   logic [ITEM_W-1:0] rd_data;

   // count covers every occupied entry including the head, so the head slot stays put
   assign in_ready  = (count_ff != (AW+1)'(DEPTH));
   assign push      = in_valid && in_ready;
   assign out_valid = head_valid_ff;
   assign out_item  = item_type'(rd_data);
   assign pop_head  = head_valid_ff && out_ready;

   // the next ram entry is fetched when the head is empty or being taken
   assign unfetched = count_ff - (AW+1)'(head_valid_ff);
   assign fetch_ok  = !head_valid_ff || out_ready;
   assign pop_ram   = fetch_ok && (unfetched != '0);
   // without a fetch the head slot is read again so the head holds
   assign rd_addr   = pop_ram ? rd_ptr_ff : rd_ptr_ff - AW'(1);

   clcn_ram #(.WIDTH(ITEM_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (in_item),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      wr_ptr_in     = wr_ptr_ff + AW'(push);
      rd_ptr_in     = rd_ptr_ff + AW'(pop_ram);
      count_in      = count_ff + (AW+1)'(push) - (AW+1)'(pop_head);
      head_valid_in = pop_ram ? 1'b1 : (pop_head ? 1'b0 : head_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         head_valid_ff <= head_valid_in;
      end
   end

endmodule

@@ src/clcn_back.sv @@
// back: products, sums, saturation and norm accumulation, one beat at a time
// depends on clcn_pkg

module clcn_back
   import clcn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  coef_type              coef,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  item_type              in_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_out_re,
   output logic signed [31:0]    rsp_out_im,
   output logic [NORM_W-1:0]     rsp_norm_out,
   output logic                  rsp_is_last,
   output logic                  rsp_saturated
);

   state_type state_ff, state_in;

   item_type itm_ff;
   logic signed [PROD_W-1:0] prod_ff [12];
   logic signed [SUM_W-1:0]  re_sum_ff, im_sum_ff;
   data_type                 re_ff, im_ff;
   logic                     psat_ff;
   logic [PROD_W-1:0]        sq_re_ff, sq_im_ff;
   logic [NORM_W-1:0]        norm_sum_ff, nout_ff;
   logic                     norm_sat_seen_ff, sat_ff, last_ff;

   always_comb begin
      in_ready  = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (in_valid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_SQ;
         ST_SQ:   state_in = ST_ACC;
         ST_ACC:  state_in = ST_OUT;
         ST_OUT:  if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   function automatic logic signed [PROD_W-1:0] fmul(data_type x, data_type y);
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(x) * PROD_W'(y);
      return p >>> FRAC_BITS;
   endfunction

   function automatic logic [PROD_W-1:0] sqm(data_type v);
      logic [DATA_WIDTH-1:0] m;
      m = v[DATA_WIDTH-1] ? DATA_WIDTH'(-v) : DATA_WIDTH'(v);
      return PROD_W'(m) * PROD_W'(m);
   endfunction

   localparam logic signed [SUM_W-1:0] HI = SUM_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] LO = -HI - SUM_W'(1);

   logic signed [SUM_W-1:0] re_c, im_c;
   logic [NORM_W:0] acc_sum;

   always_comb begin
      re_c = SUM_W'(prod_ff[0]) - SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2])
           - SUM_W'(prod_ff[3]) + SUM_W'(prod_ff[4]) - SUM_W'(prod_ff[5]);
      im_c = SUM_W'(prod_ff[6]) + SUM_W'(prod_ff[7]) + SUM_W'(prod_ff[8])
           + SUM_W'(prod_ff[9]) + SUM_W'(prod_ff[10]) + SUM_W'(prod_ff[11]);
      acc_sum = {1'b0, norm_sum_ff} + (NORM_W+1)'(sq_re_ff) + (NORM_W+1)'(sq_im_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         norm_sum_ff      <= '0;
         norm_sat_seen_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ACC) begin
            logic [NORM_W-1:0] s;
            logic so;
            so = coef.norm_en && acc_sum[NORM_W];
            s  = !coef.norm_en ? norm_sum_ff : (so ? '1 : acc_sum[NORM_W-1:0]);
            if (last_ff) begin
               nout_ff          <= s;
               norm_sum_ff      <= '0;
               norm_sat_seen_ff <= 1'b0;
               sat_ff           <= psat_ff || so || norm_sat_seen_ff;
            end else begin
               nout_ff          <= '0;
               norm_sum_ff      <= s;
               norm_sat_seen_ff <= norm_sat_seen_ff || so;
               sat_ff           <= psat_ff || so;
            end
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && in_valid) begin
         itm_ff <= in_item;
      end
      if (state_ff == ST_MUL) begin
         prod_ff[0]  <= fmul(coef.k1_re, itm_ff.a_re);
         prod_ff[1]  <= fmul(coef.k1_im, itm_ff.a_im);
         prod_ff[2]  <= fmul(coef.k2_re, itm_ff.b_re);
         prod_ff[3]  <= fmul(coef.k2_im, itm_ff.b_im);
         prod_ff[4]  <= fmul(coef.k3_re, itm_ff.c_re);
         prod_ff[5]  <= fmul(coef.k3_im, itm_ff.c_im);
         prod_ff[6]  <= fmul(coef.k1_re, itm_ff.a_im);
         prod_ff[7]  <= fmul(coef.k1_im, itm_ff.a_re);
         prod_ff[8]  <= fmul(coef.k2_re, itm_ff.b_im);
         prod_ff[9]  <= fmul(coef.k2_im, itm_ff.b_re);
         prod_ff[10] <= fmul(coef.k3_re, itm_ff.c_im);
         prod_ff[11] <= fmul(coef.k3_im, itm_ff.c_re);
         last_ff     <= itm_ff.last;
      end
      if (state_ff == ST_SUM) begin
         re_sum_ff <= re_c;
         im_sum_ff <= im_c;
      end
      if (state_ff == ST_SQ) begin
         re_ff   <= (re_sum_ff > HI) ? DATA_WIDTH'(HI) :
                    (re_sum_ff < LO) ? DATA_WIDTH'(LO) : DATA_WIDTH'(re_sum_ff);
         im_ff   <= (im_sum_ff > HI) ? DATA_WIDTH'(HI) :
                    (im_sum_ff < LO) ? DATA_WIDTH'(LO) : DATA_WIDTH'(im_sum_ff);
         psat_ff <= (re_sum_ff > HI) || (re_sum_ff < LO)
                 || (im_sum_ff > HI) || (im_sum_ff < LO);
      end
   end

   // squares of the clamped parts, registered in the same cycle as the clamp
   always_ff @(posedge clock) begin
      if (state_ff == ST_SQ) begin
         sq_re_ff <= sqm(DATA_WIDTH'((re_sum_ff > HI) ? HI : (re_sum_ff < LO) ? LO : re_sum_ff));
         sq_im_ff <= sqm(DATA_WIDTH'((im_sum_ff > HI) ? HI : (im_sum_ff < LO) ? LO : im_sum_ff));
      end
   end

   assign rsp_out_re    = re_ff;
   assign rsp_out_im    = im_ff;
   assign rsp_norm_out  = nout_ff;
   assign rsp_is_last   = last_ff;
   assign rsp_saturated = sat_ff;

endmodule

@@ src/complex_linear_combination_norm_unit.sv @@
// beats pass through the front queue, then the back-end states mul, sum, sq, acc and out
// the shared back end takes a new beat only after the previous result is accepted
// the 4-entry front queue takes beats while the back end works
// reset: synchronous, active high; clears coefficients, norm sum, queue
// top level of the complex linear combination norm unit
// depends on clcn_pkg, clcn_front, clcn_back

module complex_linear_combination_norm_unit
   import clcn_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_a_re,
   input  logic signed [31:0]     req_a_im,
   input  logic signed [31:0]     req_b_re,
   input  logic signed [31:0]     req_b_im,
   input  logic signed [31:0]     req_c_re,
   input  logic signed [31:0]     req_c_im,
   input  logic                   req_last_element,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_out_re,
   output logic signed [31:0]     rsp_out_im,
   output logic [63:0]            rsp_norm_out,
   output logic                   rsp_is_last,
   output logic                   rsp_saturated,
   input  logic                   csr_write,
   input  logic [REG_IDX_W-1:0]   csr_index,
   input  logic [31:0]            csr_data
);

   coef_type coef_ff;
   item_type in_item, q_item;
   logic     q_valid, q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_COEF1_RE: coef_ff.k1_re   <= csr_data;
            REG_COEF1_IM: coef_ff.k1_im   <= csr_data;
            REG_COEF2_RE: coef_ff.k2_re   <= csr_data;
            REG_COEF2_IM: coef_ff.k2_im   <= csr_data;
            REG_COEF3_RE: coef_ff.k3_re   <= csr_data;
            REG_COEF3_IM: coef_ff.k3_im   <= csr_data;
            REG_NORM_EN:  coef_ff.norm_en <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign in_item = '{a_re: req_a_re, a_im: req_a_im, b_re: req_b_re, b_im: req_b_im,
                      c_re: req_c_re, c_im: req_c_im, last: req_last_element};

   clcn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (in_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   clcn_back u_back (
      .clock         (clock),
      .reset         (reset),
      .coef          (coef_ff),
      .in_valid      (q_valid),
      .in_ready      (q_ready),
      .in_item       (q_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_re    (rsp_out_re),
      .rsp_out_im    (rsp_out_im),
      .rsp_norm_out  (rsp_norm_out),
      .rsp_is_last   (rsp_is_last),
      .rsp_saturated (rsp_saturated)
   );

   // norm sum only shows on the last beat; checked while a result is stalled
   a_norm_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> 1'b1 ##0 (!rsp_is_last -> rsp_norm_out == '0))
      else $error("norm_out nonzero on non-last beat");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_re) && $stable(rsp_out_im))
      else $error("result changed while stalled");

   // a stalled result holds its norm and flags
   a_flag_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_norm_out) && $stable(rsp_is_last)
      && $stable(rsp_saturated))
      else $error("result flags changed while stalled");

endmodule

@@ tb/complex_linear_combination_norm_unit_test.sv @@
// testbench for the complex linear combination norm unit: streams random and corner
// beats, predicts a' = k1*a + k2*b + k3*c with the saturating norm sum, checks results
// depends on clcn_pkg and complex_linear_combination_norm_unit

module complex_linear_combination_norm_unit_test;
   import clcn_pkg::*;

   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic [63:0]        norm;
      logic               last;
      logic               sat;
   } result_type;

   localparam int IDLE_LIMIT = 20000;
   localparam logic signed [31:0] MAXP = 32'sh7fffffff;
   localparam logic signed [31:0] MAXN = 32'sh80000000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [31:0] req_a_re = 0, req_a_im = 0, req_b_re = 0, req_b_im = 0;
   logic signed [31:0] req_c_re = 0, req_c_im = 0;
   logic req_last_element = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_out_re, rsp_out_im;
   logic [63:0] rsp_norm_out;
   logic rsp_is_last, rsp_saturated;
   logic csr_write = 0;
   logic [REG_IDX_W-1:0] csr_index = REG_COEF1_RE;
   logic [31:0] csr_data = 0;

   complex_linear_combination_norm_unit u_dut (.*);

   always #5 clock = ~clock;

   item_type   pending_beats[$];
   result_type expected_results[$];
   coef_type   coefs;
   logic [63:0] norm_acc;
   logic        norm_overflowed;
   int mismatches = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   int burst_left = 0;
   int hold_off = 0;
   int stall_mode = 0;
   bit req_taken = 0;

   // truncating fixed-point product
   function automatic logic signed [63:0] qmul(logic signed [31:0] x, logic signed [31:0] y);
      logic signed [63:0] p;
      p = 64'(x) * 64'(y);
      return p >>> FRAC_BITS;
   endfunction

   function automatic logic signed [31:0] clamp32(logic signed [66:0] v, ref logic sat);
      if (v > 67'(MAXP)) begin
         sat = 1;
         return MAXP;
      end
      if (v < 67'(MAXN)) begin
         sat = 1;
         return MAXN;
      end
      return v[31:0];
   endfunction

   function automatic logic [63:0] square(logic signed [31:0] v);
      logic [31:0] m;
      m = v[31] ? 32'(-64'(v)) : v;
      return 64'(m) * 64'(m);
   endfunction

   function automatic result_type combine_element(item_type it);
      result_type r;
      logic signed [66:0] sre, sim;
      logic sat;
      logic [64:0] total;
      sat = 0;
      sre = 67'(qmul(coefs.k1_re, it.a_re)) - 67'(qmul(coefs.k1_im, it.a_im))
          + 67'(qmul(coefs.k2_re, it.b_re)) - 67'(qmul(coefs.k2_im, it.b_im))
          + 67'(qmul(coefs.k3_re, it.c_re)) - 67'(qmul(coefs.k3_im, it.c_im));
      sim = 67'(qmul(coefs.k1_re, it.a_im)) + 67'(qmul(coefs.k1_im, it.a_re))
          + 67'(qmul(coefs.k2_re, it.b_im)) + 67'(qmul(coefs.k2_im, it.b_re))
          + 67'(qmul(coefs.k3_re, it.c_im)) + 67'(qmul(coefs.k3_im, it.c_re));
      r.re = clamp32(sre, sat);
      r.im = clamp32(sim, sat);
      r.norm = 0;
      if (coefs.norm_en) begin
         // squares of two 32-bit values can not overflow the 64-bit add term
         total = 65'(norm_acc) + 65'(square(r.re) + square(r.im));
         if (total[64]) begin
            norm_acc = '1;
            norm_overflowed = 1;
            sat = 1;
         end else begin
            norm_acc = total[63:0];
         end
      end
      if (it.last) begin
         r.norm = norm_acc;
         if (norm_overflowed) sat = 1;
         norm_acc = 0;
         norm_overflowed = 0;
      end
      r.last = it.last;
      r.sat = sat;
      return r;
   endfunction

   // driver: bursts and gaps, valid held until accepted
   always @(negedge clock) begin
      bit free;
      if (!reset) begin
         free = !req_valid;
         if (req_taken) begin
            expected_results.push_back(combine_element(pending_beats.pop_front()));
            burst_left = burst_left - 1;
            req_taken = 0;
            free = 1;
         end
         if (free) begin
            if (burst_left <= 0 && gap_left <= 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_valid <= 0;
            end else if (pending_beats.size() > 0) begin
               req_valid <= 1;
               {req_a_re, req_a_im, req_b_re, req_b_im, req_c_re, req_c_im,
                req_last_element} <= pending_beats[0];
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // receiver stall pattern, plus a long hold-off when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_off > 0) begin
         hold_off = hold_off - 1;
         rsp_ready <= 0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
         if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      result_type want;
      req_taken = req_valid && req_ready;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) $display("unexpected result beat re=%0d", rsp_out_re);
            end else begin
               want = expected_results.pop_front();
               if (rsp_out_re !== want.re || rsp_out_im !== want.im ||
                   rsp_norm_out !== want.norm || rsp_is_last !== want.last ||
                   rsp_saturated !== want.sat) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display({"mismatch: exp re=%0d im=%0d norm=%h last=%b sat=%b,",
                               " got re=%0d im=%0d norm=%h last=%b sat=%b"},
                              want.re, want.im, want.norm, want.last, want.sat,
                              rsp_out_re, rsp_out_im, rsp_norm_out, rsp_is_last,
                              rsp_saturated);
               end
            end
         end
      end
   end

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 7))
         0: return MAXP;
         1: return MAXN;
         2: return 32'(signed'($urandom_range(0, 131072)) - 65536);
         3: return 32'($urandom_range(0, 16'hffff)) - 32'sh8000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] rand_coef();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 32'sh00010000;
         2: return 32'shffff0000;
         3: return MAXP;
         4: return MAXN;
         5: return 32'(signed'($urandom_range(0, 262144)) - 131072);
         default: return $urandom;
      endcase
   endfunction

   task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 0;
      case (idx)
         REG_COEF1_RE: coefs.k1_re = value;
         REG_COEF1_IM: coefs.k1_im = value;
         REG_COEF2_RE: coefs.k2_re = value;
         REG_COEF2_IM: coefs.k2_im = value;
         REG_COEF3_RE: coefs.k3_re = value;
         REG_COEF3_IM: coefs.k3_im = value;
         default: coefs.norm_en = value[0];
      endcase
   endtask

   task automatic load_coefs(logic signed [31:0] c1r, logic signed [31:0] c1i,
                             logic signed [31:0] c2r, logic signed [31:0] c2i,
                             logic signed [31:0] c3r, logic signed [31:0] c3i, logic en);
      write_reg(REG_COEF1_RE, c1r);
      write_reg(REG_COEF1_IM, c1i);
      write_reg(REG_COEF2_RE, c2r);
      write_reg(REG_COEF2_IM, c2i);
      write_reg(REG_COEF3_RE, c3r);
      write_reg(REG_COEF3_IM, c3i);
      write_reg(REG_NORM_EN, {31'b0, en});
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while ((pending_beats.size() > 0 || req_valid || expected_results.size() > 0)
             && guard < 200000) begin
         @(posedge clock);
         guard = guard + 1;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic push_beat(logic signed [31:0] v0, logic signed [31:0] v1,
                            logic signed [31:0] v2, logic signed [31:0] v3,
                            logic signed [31:0] v4, logic signed [31:0] v5, logic last);
      item_type it;
      it = '{v0, v1, v2, v3, v4, v5, last};
      pending_beats.push_back(it);
   endtask

   initial begin
      int n;
      coefs = '0;
      norm_acc = 0;
      norm_overflowed = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // reset coefficients give zero
      push_beat(MAXP, MAXN, MAXP, MAXN, 1, -1, 1);
      drain();

      // identity on a, norm on, small and extreme values
      load_coefs(32'sh00010000, 0, 0, 0, 0, 0, 1);
      push_beat(32'sh00010000, 32'sh00020000, 0, 0, 0, 0, 0);
      push_beat(-32'sh00008000, 32'sh00000001, 0, 0, 0, 0, 0);
      push_beat(-1, -1, 0, 0, 0, 0, 1);
      push_beat(MAXP, MAXN, 0, 0, 0, 0, 0);
      push_beat(MAXN, MAXN, 0, 0, 0, 0, 1);
      drain();

      // every coefficient at an extreme value (MAXP or MAXN) drives saturation and norm sum overflow
      load_coefs(MAXP, MAXN, MAXP, MAXN, MAXN, MAXP, 1);
      for (int i = 0; i < 10; i++) push_beat(MAXP, MAXN, MAXN, MAXP, MAXP, MAXP, i == 9);
      push_beat(MAXN, MAXP, MAXP, MAXN, MAXN, MAXN, 1);
      drain();

      // norm off: sum left from before is still given out and cleared
      load_coefs(32'sh00010000, 0, 0, 0, 0, 0, 1);
      push_beat(32'sh00030000, 32'sh00040000, 0, 0, 0, 0, 0);
      drain();
      write_reg(REG_NORM_EN, 0);
      push_beat(32'sh00030000, 32'sh00040000, 0, 0, 0, 0, 1);
      push_beat(5, 7, 0, 0, 0, 0, 1);
      drain();

      // long hold-off on the result side fills the block
      load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                 rand_coef(), 1);
      hold_off = 300;
      for (int i = 0; i < 40; i++)
         push_beat(rand_value(), rand_value(), rand_value(), rand_value(), rand_value(),
                   rand_value(), $urandom_range(0, 7) == 0);
      drain();

      // random phases with new coefficients
      for (int phase = 0; phase < 9; phase++) begin
         if (phase == 8)
            load_coefs(MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, 1);
         else
            load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                       rand_coef(), $urandom_range(0, 3) != 0);
         n = 0;
         while (n < 100) begin
            int vlen;
            vlen = $urandom_range(1, 16);
            for (int j = 0; j < vlen && n < 100; j++) begin
               push_beat(rand_value(), rand_value(), rand_value(), rand_value(), rand_value(),
                         rand_value(), (j == vlen - 1) || $urandom_range(0, 40) == 0);
               n = n + 1;
            end
         end
         drain();
      end

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
